@@ rtl/core/postfix_stack_calculator_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the postfix stack calculator
// Clocked on clk, disabled while arst_n is low; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_STACK_CALCULATOR_CORE_ASSERT_SVH
`define POSTFIX_STACK_CALCULATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Property holds at every clock edge out of reset
`define PSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Antecedent this cycle implies consequent next cycle
`define PSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PSC_ASSERT(lbl, prop, msg)
`define PSC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/core/psc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_pkg
// Types and codes shared by the postfix stack calculator modules.
// ----------------------------------------------------------------------------
package psc_pkg;

	typedef enum logic [2:0] {
		OP_PUSH = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4,
		OP_POP  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ERR_OK      = 2'd0,
		ERR_UNDER   = 2'd1,
		ERR_OVER    = 2'd2,
		ERR_DIVZERO = 2'd3
	} err_t;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] value;
	} psc_in_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [6:0]         depth;
		logic [1:0]         error_code;
	} psc_out_t;

	// Sequencer of the top level
	typedef enum logic [2:0] {
		S_IDLE,
		S_TAKE_R,
		S_TAKE_L,
		S_START,
		S_WAIT,
		S_RESP
	} seq_state_t;

	// Shared arithmetic unit
	typedef enum logic [1:0] {
		A_IDLE,
		A_RUN,
		A_FIX,
		A_DONE
	} alu_state_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} alu_cmd_t;

	typedef struct packed {
		logic done;
		logic div_zero;
	} alu_sts_t;

	localparam int WORD_W = 32;
	localparam logic [4:0] LAST_STEP = 5'd31;

endpackage

@@ rtl/core/psc_stack_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_stack_mem
// Stack word store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module psc_stack_mem import psc_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [WORD_W-1:0] wr_data,
	input  logic [AW-1:0]     rd_addr,
	output logic [WORD_W-1:0] rd_data
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/core/psc_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_alu
// Iterative arithmetic unit around one 33-bit adder: add and subtract in one
// step, multiply by shift-add and divide by restoring radix-2 in 32 steps.
// ----------------------------------------------------------------------------
module psc_alu import psc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  alu_cmd_t          cmd,
	input  logic [WORD_W-1:0] left_operand,
	input  logic [WORD_W-1:0] right_operand,
	output alu_sts_t          sts,
	output logic [WORD_W-1:0] result
);

	alu_state_t        st_q, st_d;
	op_t               op_q, op_d;
	logic [WORD_W:0]   acc_q, acc_d;
	logic [WORD_W-1:0] x_q, x_d;
	logic [WORD_W-1:0] y_q, y_d;
	logic              neg_q, neg_d;
	logic              dz_q, dz_d;
	logic [4:0]        step_q, step_d;

	logic [WORD_W:0]   add_a, add_b, sum;
	logic              add_sub;
	logic [WORD_W-1:0] lmag, rmag;

	assign lmag = left_operand[WORD_W-1] ? (WORD_W'(0) - left_operand) : left_operand;
	assign rmag = right_operand[WORD_W-1] ? (WORD_W'(0) - right_operand) : right_operand;

	// the one shared adder
	assign sum = add_a + (add_sub ? ~add_b : add_b) + (WORD_W+1)'(add_sub);

	always_comb begin
		add_a   = {1'b0, x_q};
		add_b   = {1'b0, y_q};
		add_sub = 1'b0;
		unique case (st_q)
			A_RUN: begin
				priority if (op_q == OP_MUL) begin
					add_a = acc_q;
					add_b = {1'b0, x_q};
				end else if (op_q == OP_DIV) begin
					add_a   = {acc_q[WORD_W-1:0], x_q[WORD_W-1]};
					add_b   = {1'b0, y_q};
					add_sub = 1'b1;
				end else begin
					add_sub = (op_q == OP_SUB);
				end
			end
			A_FIX: begin
				// quotient sign fix: 0 - q or 0 + q
				add_a   = '0;
				add_b   = {1'b0, x_q};
				add_sub = neg_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		st_d   = st_q;
		op_d   = op_q;
		acc_d  = acc_q;
		x_d    = x_q;
		y_d    = y_q;
		neg_d  = neg_q;
		dz_d   = dz_q;
		step_d = step_q;
		unique case (st_q)
			A_IDLE: begin
				if (cmd.start) begin
					op_d   = cmd.op;
					step_d = '0;
					dz_d   = 1'b0;
					acc_d  = '0;
					neg_d  = left_operand[WORD_W-1] ^ right_operand[WORD_W-1];
					if (cmd.op == OP_DIV) begin
						x_d = lmag;
						y_d = rmag;
						if (right_operand == '0) begin
							dz_d = 1'b1;
							st_d = A_DONE;
						end else begin
							st_d = A_RUN;
						end
					end else begin
						x_d  = left_operand;
						y_d  = right_operand;
						st_d = A_RUN;
					end
				end
			end
			A_RUN: begin
				priority if (op_q == OP_MUL) begin
					if (y_q[0]) begin
						acc_d = sum;
					end
					x_d    = {x_q[WORD_W-2:0], 1'b0};
					y_d    = {1'b0, y_q[WORD_W-1:1]};
					step_d = step_q + 5'd1;
					if (step_q == LAST_STEP) begin
						st_d = A_DONE;
					end
				end else if (op_q == OP_DIV) begin
					if (!sum[WORD_W]) begin
						acc_d = sum;
						x_d   = {x_q[WORD_W-2:0], 1'b1};
					end else begin
						acc_d = add_a;
						x_d   = {x_q[WORD_W-2:0], 1'b0};
					end
					step_d = step_q + 5'd1;
					if (step_q == LAST_STEP) begin
						st_d = A_FIX;
					end
				end else begin
					acc_d = sum;
					st_d  = A_DONE;
				end
			end
			A_FIX: begin
				acc_d = sum;
				st_d  = A_DONE;
			end
			A_DONE: begin
				st_d = A_IDLE;
			end
			default: st_d = A_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= A_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q   <= op_d;
		acc_q  <= acc_d;
		x_q    <= x_d;
		y_q    <= y_d;
		neg_q  <= neg_d;
		dz_q   <= dz_d;
		step_q <= step_d;
	end

	assign sts.done     = (st_q == A_DONE);
	assign sts.div_zero = dz_q;
	assign result       = acc_q[WORD_W-1:0];

endmodule

@@ rtl/core/postfix_stack_calculator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_stack_calculator_core
// Postfix calculator on a bounded stack of 32-bit signed words.
// ----------------------------------------------------------------------------
// Usage: items come in on item/item_valid/item_ready, one result per item
// goes out on result/result_valid/result_ready. A transfer happens when valid
// and ready are both high at a rising clock edge.
// The sequencer takes no new item until the last one reaches the response
// state. The shared unit's 32 multiply or divide steps dominate the work; the
// stack store reads one word a cycle, so operands arrive one by one.
// The result is registered, then loaded from the response state into an
// output register; the block takes the next item while it waits there.
// If the receiver stalls with a result still held, the next result is parked
// until the output register frees up, and item_ready stays low meanwhile.
// Reset empties the stack (depth zero); store contents are not cleared.
// ----------------------------------------------------------------------------
`include "postfix_stack_calculator_core_assert.svh"

module postfix_stack_calculator_core import psc_pkg::*; #(
	parameter int STACK_DEPTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  psc_in_t  item,
	output logic     result_valid,
	input  logic     result_ready,
	output psc_out_t result
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	seq_state_t        state_q, state_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	op_t               op_q, op_d;
	logic              ok_r_q, ok_r_d;
	logic              ok_l_q, ok_l_d;
	logic [WORD_W-1:0] right_q, right_d;
	logic [WORD_W-1:0] left_q, left_d;
	logic [WORD_W-1:0] res_q, res_d;
	err_t              err_q, err_d;
	psc_out_t          out_q;
	logic              out_valid_q;

	logic              has_room, not_empty, out_load;
	logic              mem_we;
	logic [WORD_W-1:0] mem_wdata, mem_rdata;
	alu_cmd_t          alu_cmd;
	alu_sts_t          alu_sts;
	logic [WORD_W-1:0] alu_result;

	assign has_room  = (cnt_q < CW'(STACK_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign out_load  = (state_q == S_RESP) && (!out_valid_q || result_ready);

	psc_stack_mem #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (AW'(cnt_q)),
		.wr_data (mem_wdata),
		// top word; after the first pop this is the left operand
		.rd_addr (AW'(cnt_q - CW'(1))),
		.rd_data (mem_rdata)
	);

	psc_alu u_alu (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (alu_cmd),
		.left_operand  (left_q),
		.right_operand (right_q),
		.sts           (alu_sts),
		.result        (alu_result)
	);

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		op_d      = op_q;
		ok_r_d    = ok_r_q;
		ok_l_d    = ok_l_q;
		right_d   = right_q;
		left_d    = left_q;
		res_d     = res_q;
		err_d     = err_q;
		mem_we    = 1'b0;
		mem_wdata = item.value;
		alu_cmd   = '{start: 1'b0, op: op_q};
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					op_d = op_t'(item.operation);
					unique case (item.operation)
						OP_PUSH: begin
							res_d = item.value;
							if (has_room) begin
								mem_we = 1'b1;
								cnt_d  = cnt_q + CW'(1);
								err_d  = ERR_OK;
							end else begin
								err_d = ERR_OVER;
							end
							state_d = S_RESP;
						end
						OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POP: begin
							ok_r_d = not_empty;
							if (not_empty) begin
								cnt_d = cnt_q - CW'(1);
							end
							state_d = S_TAKE_R;
						end
						default: begin
							res_d   = '0;
							err_d   = ERR_OK;
							state_d = S_RESP;
						end
					endcase
				end
			end
			S_TAKE_R: begin
				// missing operand reads as all ones
				right_d = ok_r_q ? mem_rdata : '1;
				if (op_q == OP_POP) begin
					res_d   = right_d;
					err_d   = ok_r_q ? ERR_OK : ERR_UNDER;
					state_d = S_RESP;
				end else begin
					ok_l_d = not_empty;
					if (not_empty) begin
						cnt_d = cnt_q - CW'(1);
					end
					state_d = S_TAKE_L;
				end
			end
			S_TAKE_L: begin
				left_d  = ok_l_q ? mem_rdata : '1;
				state_d = S_START;
			end
			S_START: begin
				alu_cmd.start = 1'b1;
				state_d       = S_WAIT;
			end
			S_WAIT: begin
				mem_wdata = alu_result;
				if (alu_sts.done) begin
					res_d = alu_result;
					if (has_room) begin
						mem_we = 1'b1;
						cnt_d  = cnt_q + CW'(1);
					end
					priority if (!ok_r_q || !ok_l_q) begin
						err_d = ERR_UNDER;
					end else if (alu_sts.div_zero) begin
						err_d = ERR_DIVZERO;
					end else begin
						err_d = ERR_OK;
					end
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q    <= op_d;
		ok_r_q  <= ok_r_d;
		ok_l_q  <= ok_l_d;
		right_q <= right_d;
		left_q  <= left_d;
		res_q   <= res_d;
		err_q   <= err_d;
		if (out_load) begin
			out_q.result_value <= res_q;
			out_q.depth        <= 7'(cnt_q);
			out_q.error_code   <= err_q;
		end
	end

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	`PSC_ASSERT(a_cnt_bound, cnt_q <= CW'(STACK_DEPTH), "stack count beyond depth")
	`PSC_ASSERT(a_wr_room, !mem_we || has_room, "store write with stack full")
	`PSC_ASSERT(a_alu_done_wait, !alu_sts.done || state_q == S_WAIT, "alu done outside wait")
	`PSC_ASSERT_NEXT(a_busy_after_xfer, item_valid && item_ready, !item_ready, "ready after transfer")
	`PSC_ASSERT_NEXT(a_resp_loads, out_load, result_valid, "result not posted")

endmodule
